>>> sv/stk_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stk_pkg
// Shared constants, types and the arctangent table of the Stokes calculator.
// ----------------------------------------------------------------------------
package stk_pkg;

    localparam int INTENSITY_BITS_DEF = 16;
    localparam int CORDIC_STEPS_DEF   = 16;

    localparam int STOKES_W = 17;
    localparam int DEG_W    = 16;
    localparam int ORI_W    = 16;
    localparam int ELL_W    = 15;
    localparam int QUO_W    = 16;

    // angle accumulator, 2^20 = pi
    localparam int ANG_W    = 23;
    localparam int ANG_PI   = 1048576;
    localparam int ATAN_LEN = 24;
    localparam int ORI_LIM  = 16384;
    localparam int ELL_LIM  = 8192;
    localparam int HALF_SH  = 6;
    localparam int HALF_RND = 32;

    // fraction bits of the two square roots
    localparam int DEG_FRAC = 14;
    localparam int LIN_FRAC = 16;

    typedef struct packed {
        logic                    null_vec;
        logic signed [ANG_W-1:0] z;
    } cordic_res_t;

    function automatic logic signed [ANG_W-1:0] atan_entry(input int idx);
        logic signed [ANG_W-1:0] v;
        case (idx)
            0:       v = ANG_W'(262144);
            1:       v = ANG_W'(154753);
            2:       v = ANG_W'(81767);
            3:       v = ANG_W'(41506);
            4:       v = ANG_W'(20834);
            5:       v = ANG_W'(10427);
            6:       v = ANG_W'(5215);
            7:       v = ANG_W'(2608);
            8:       v = ANG_W'(1304);
            9:       v = ANG_W'(652);
            10:      v = ANG_W'(326);
            11:      v = ANG_W'(163);
            12:      v = ANG_W'(81);
            13:      v = ANG_W'(41);
            14:      v = ANG_W'(20);
            15:      v = ANG_W'(10);
            16:      v = ANG_W'(5);
            17:      v = ANG_W'(3);
            18:      v = ANG_W'(1);
            19:      v = ANG_W'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

    // round the accumulator to the output scale and clamp it; a null vector gives 0
    function automatic logic signed [ANG_W-1:0] half_angle(input cordic_res_t r,
                                                            input int lim);
        logic signed [ANG_W-1:0] q;
        logic signed [ANG_W-1:0] hi;
        q  = (r.z + ANG_W'(HALF_RND)) >>> HALF_SH;
        hi = ANG_W'(lim);
        if (r.null_vec) begin
            q = '0;
        end else if (q > hi) begin
            q = hi;
        end else if (q < -hi) begin
            q = -hi;
        end
        return q;
    endfunction

endpackage
`default_nettype wire

>>> sv/stk_delay.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stk_delay
// Enabled register chain that keeps side data aligned with the pipeline.
// ----------------------------------------------------------------------------
module stk_delay #(
    parameter int W     = 8,
    parameter int DEPTH = 1
) (
    input  wire logic         aclk,
    input  wire logic         en,
    input  wire logic [W-1:0] d_in,
    output logic      [W-1:0] d_out
);

    generate
        if (DEPTH == 0) begin : g_none
            assign d_out = d_in;
        end else begin : g_chain
            logic [W-1:0] tap_reg [0:DEPTH-1];
            always_ff @(posedge aclk) begin
                if (en) begin
                    tap_reg[0] <= d_in;
                    for (int i = 1; i < DEPTH; i++) begin
                        tap_reg[i] <= tap_reg[i-1];
                    end
                end
            end
            assign d_out = tap_reg[DEPTH-1];
        end
    endgenerate

endmodule
`default_nettype wire

>>> sv/stk_sqrt.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stk_sqrt
// Pipelined digit-by-digit square root, floor(sqrt(m) * 2^FRAC).
// One root bit per stage.
// ----------------------------------------------------------------------------
module stk_sqrt #(
    parameter int IN_W = 34,
    parameter int FRAC = 14
) (
    input  wire logic                      aclk,
    input  wire logic                      en,
    input  wire logic [IN_W-1:0]           m_in,
    output logic      [IN_W/2+FRAC-1:0]    root_out
);

    localparam int MK   = IN_W / 2;
    localparam int RW   = MK + FRAC;
    localparam int REMW = RW + 2;

    logic [REMW-1:0] rem_reg  [0:RW-2];
    logic [RW-1:0]   root_reg [0:RW-1];
    logic [IN_W-1:0] m_reg    [0:MK-2];

    genvar k;
    generate
        for (k = 0; k < RW; k++) begin : g_stage
            logic [REMW-1:0] rem_prev;
            logic [REMW-1:0] rem_sh;
            logic [REMW-1:0] trial;
            logic [RW-1:0]   root_prev;
            logic [1:0]      pair;

            if (k == 0) begin : g_first
                assign rem_prev  = '0;
                assign root_prev = '0;
            end else begin : g_rest
                assign rem_prev  = rem_reg[k-1];
                assign root_prev = root_reg[k-1];
            end

            if (k < MK) begin : g_int
                logic [IN_W-1:0] m_prev;
                if (k == 0) begin : g_m0
                    assign m_prev = m_in;
                end else begin : g_mk
                    assign m_prev = m_reg[k-1];
                end
                assign pair = m_prev[2*(MK-1-k)+1 -: 2];
                if (k < MK - 1) begin : g_pass
                    always_ff @(posedge aclk) begin
                        if (en) begin
                            m_reg[k] <= m_prev;
                        end
                    end
                end
            end else begin : g_frac
                assign pair = 2'b00;
            end

            assign rem_sh = {rem_prev[REMW-3:0], pair};
            assign trial  = {root_prev, 2'b01};

            always_ff @(posedge aclk) begin
                if (en) begin
                    root_reg[k] <= {root_prev[RW-2:0], (rem_sh >= trial)};
                end
            end

            if (k < RW - 1) begin : g_rem
                always_ff @(posedge aclk) begin
                    if (en) begin
                        rem_reg[k] <= (rem_sh >= trial) ? rem_sh - trial : rem_sh;
                    end
                end
            end
        end
    endgenerate

    assign root_out = root_reg[RW-1];

endmodule
`default_nettype wire

>>> sv/stk_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stk_div
// Pipelined restoring divider with a saturating 16-bit quotient.
// One overflow check stage, then one quotient bit per stage.
// ----------------------------------------------------------------------------
module stk_div
    import stk_pkg::*;
#(
    parameter int NW = 31,
    parameter int DW = 17
) (
    input  wire logic             aclk,
    input  wire logic             en,
    input  wire logic [NW-1:0]    num_in,
    input  wire logic [DW-1:0]    den_in,
    output logic      [QUO_W-1:0] quo_out
);

    localparam int RMW = DW + QUO_W;
    localparam int CW  = (NW > RMW) ? NW : RMW;

    logic [RMW-1:0]   rem_reg [0:QUO_W-1];
    logic [DW-1:0]    den_reg [0:QUO_W-1];
    logic             ovf_reg [0:QUO_W];
    logic [QUO_W-1:0] quo_reg [0:QUO_W];

    logic ovf_next;
    assign ovf_next = CW'(num_in) >= CW'({den_in, {QUO_W{1'b0}}});

    always_ff @(posedge aclk) begin
        if (en) begin
            ovf_reg[0] <= ovf_next;
            rem_reg[0] <= ovf_next ? '0 : RMW'(num_in);
            den_reg[0] <= den_in;
            quo_reg[0] <= '0;
        end
    end

    genvar k;
    generate
        for (k = 1; k <= QUO_W; k++) begin : g_bit
            logic [RMW-1:0] sub;
            logic           take;
            assign sub  = RMW'(den_reg[k-1]) << (QUO_W - k);
            assign take = rem_reg[k-1] >= sub;

            always_ff @(posedge aclk) begin
                if (en) begin
                    ovf_reg[k] <= ovf_reg[k-1];
                    quo_reg[k] <= quo_reg[k-1] | (take ? QUO_W'(1) << (QUO_W - k) : '0);
                end
            end

            if (k < QUO_W) begin : g_carry
                always_ff @(posedge aclk) begin
                    if (en) begin
                        rem_reg[k] <= take ? rem_reg[k-1] - sub : rem_reg[k-1];
                        den_reg[k] <= den_reg[k-1];
                    end
                end
            end
        end
    endgenerate

    assign quo_out = ovf_reg[QUO_W] ? '1 : quo_reg[QUO_W];

endmodule
`default_nettype wire

>>> sv/stk_cordic.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stk_cordic
// Pipelined vectoring CORDIC, atan2(y, x) with 2^20 = pi.
// A quadrant stage folds x < 0 into the right half plane, then one
// micro-rotation per stage.
// ----------------------------------------------------------------------------
module stk_cordic
    import stk_pkg::*;
#(
    parameter int XW    = 34,
    parameter int STEPS = CORDIC_STEPS_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 en,
    input  wire logic signed [XW-1:0] x_in,
    input  wire logic signed [XW-1:0] y_in,
    output cordic_res_t               res_out
);

    localparam int N  = (STEPS < ATAN_LEN) ? STEPS : ATAN_LEN;
    localparam int CW = XW + 2;
    localparam logic signed [ANG_W-1:0] Z_PI = ANG_W'(ANG_PI);

    logic signed [CW-1:0]    x_reg   [0:N];
    logic signed [CW-1:0]    y_reg   [0:N];
    logic signed [ANG_W-1:0] z_reg   [0:N];
    logic                    nul_reg [0:N];

    logic signed [CW-1:0]    x_ext, y_ext, x0_next, y0_next;
    logic signed [ANG_W-1:0] z0_next;

    always_comb begin
        x_ext   = CW'(x_in);
        y_ext   = CW'(y_in);
        x0_next = x_ext;
        y0_next = y_ext;
        z0_next = '0;
        if (x_in < 0) begin
            x0_next = -x_ext;
            y0_next = -y_ext;
            z0_next = (y_in >= 0) ? Z_PI : -Z_PI;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg[0]   <= x0_next;
            y_reg[0]   <= y0_next;
            z_reg[0]   <= z0_next;
            nul_reg[0] <= (x_in == 0) && (y_in == 0);
        end
    end

    genvar k;
    generate
        for (k = 0; k < N; k++) begin : g_rot
            always_ff @(posedge aclk) begin
                if (en) begin
                    nul_reg[k+1] <= nul_reg[k];
                    if (y_reg[k] >= 0) begin
                        x_reg[k+1] <= x_reg[k] + (y_reg[k] >>> k);
                        y_reg[k+1] <= y_reg[k] - (x_reg[k] >>> k);
                        z_reg[k+1] <= z_reg[k] + atan_entry(k);
                    end else begin
                        x_reg[k+1] <= x_reg[k] - (y_reg[k] >>> k);
                        y_reg[k+1] <= y_reg[k] + (x_reg[k] >>> k);
                        z_reg[k+1] <= z_reg[k] - atan_entry(k);
                    end
                end
            end
        end
    endgenerate

    assign res_out.null_vec = nul_reg[N];
    assign res_out.z        = z_reg[N];

endmodule
`default_nettype wire

>>> sv/stokes_parameter_calculator_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stokes_parameter_calculator_top
// Stokes vector, degree of polarization and ellipse angles from six
// analyser intensities.
// ----------------------------------------------------------------------------
// Fully pipelined: one sample per clock, no gaps between samples, while the
// result side accepts. At the default settings the longest path is the
// linear-part square root, one bit per stage, followed by the ellipticity
// CORDIC; the degree path (square root, then a one-bit-per-stage divider)
// runs in parallel. A stall on the result side holds the whole pipeline, and
// s_ready follows m_ready directly once a result is waiting.
// ----------------------------------------------------------------------------
module stokes_parameter_calculator_top
    import stk_pkg::*;
#(
    parameter int INTENSITY_BITS = INTENSITY_BITS_DEF,
    parameter int CORDIC_STEPS   = CORDIC_STEPS_DEF
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire logic [INTENSITY_BITS-1:0] s_int_horizontal,
    input  wire logic [INTENSITY_BITS-1:0] s_int_vertical,
    input  wire logic [INTENSITY_BITS-1:0] s_int_diag_plus,
    input  wire logic [INTENSITY_BITS-1:0] s_int_diag_minus,
    input  wire logic [INTENSITY_BITS-1:0] s_int_circ_plus,
    input  wire logic [INTENSITY_BITS-1:0] s_int_circ_minus,
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output logic        [STOKES_W-1:0]     m_stokes_s0,
    output logic signed [STOKES_W-1:0]     m_stokes_s1,
    output logic signed [STOKES_W-1:0]     m_stokes_s2,
    output logic signed [STOKES_W-1:0]     m_stokes_s3,
    output logic        [DEG_W-1:0]        m_degree,
    output logic signed [ORI_W-1:0]        m_orientation,
    output logic signed [ELL_W-1:0]        m_ellipticity,
    output logic                           m_zero_intensity
);

    localparam int IB   = INTENSITY_BITS;
    localparam int SW   = IB + 1;
    localparam int SQW  = 2 * IB;
    localparam int LW   = 2 * IB + 2;
    localparam int LRW  = LW / 2 + LIN_FRAC;
    localparam int TRW  = LW / 2 + DEG_FRAC;
    localparam int XW   = IB + 18;
    localparam int NST  = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;
    localparam int CRW  = $bits(cordic_res_t);
    // register times, input register = 1
    localparam int TC   = 3 + LRW + 1 + NST;
    localparam int TD   = 3 + TRW + 1 + QUO_W;
    localparam int TE   = (TC > TD) ? TC : TD;

    logic m_valid_reg;
    logic adv;
    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;

    // valid chain
    logic valid_reg [1:TE];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 1; i <= TE; i++) begin
                valid_reg[i] <= 1'b0;
            end
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg[1] <= s_valid;
            for (int i = 2; i <= TE; i++) begin
                valid_reg[i] <= valid_reg[i-1];
            end
            m_valid_reg <= valid_reg[TE];
        end
    end

    // stage A: Stokes vector
    logic        [SW-1:0] s0_reg;
    logic signed [SW-1:0] s1_reg, s2_reg, s3_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            s0_reg <= SW'(s_int_horizontal) + SW'(s_int_vertical);
            s1_reg <= signed'({1'b0, s_int_horizontal}) - signed'({1'b0, s_int_vertical});
            s2_reg <= signed'({1'b0, s_int_diag_plus}) - signed'({1'b0, s_int_diag_minus});
            s3_reg <= signed'({1'b0, s_int_circ_plus}) - signed'({1'b0, s_int_circ_minus});
        end
    end

    // stage B: squares
    logic signed [2*SW-1:0] p1, p2, p3;
    logic [SQW-1:0] sq1_reg, sq2_reg, sq3_reg;

    assign p1 = s1_reg * s1_reg;
    assign p2 = s2_reg * s2_reg;
    assign p3 = s3_reg * s3_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            sq1_reg <= p1[SQW-1:0];
            sq2_reg <= p2[SQW-1:0];
            sq3_reg <= p3[SQW-1:0];
        end
    end

    // stage C: sums of squares
    logic [LW-1:0] lin_reg, tot_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            lin_reg <= LW'(sq1_reg) + LW'(sq2_reg);
            tot_reg <= LW'(sq1_reg) + LW'(sq2_reg) + LW'(sq3_reg);
        end
    end

    // square roots
    logic [LRW-1:0] lin_root;
    logic [TRW-1:0] tot_root;

    stk_sqrt #(.IN_W(LW), .FRAC(LIN_FRAC)) u_sqrt_lin (
        .aclk     (aclk),
        .en       (adv),
        .m_in     (lin_reg),
        .root_out (lin_root)
    );

    stk_sqrt #(.IN_W(LW), .FRAC(DEG_FRAC)) u_sqrt_tot (
        .aclk     (aclk),
        .en       (adv),
        .m_in     (tot_reg),
        .root_out (tot_root)
    );

    // align S1..S3 with the linear root for the angle units
    logic [3*SW-1:0] ang_src;
    logic signed [SW-1:0] a1, a2, a3;

    stk_delay #(.W(3*SW), .DEPTH(2 + LRW)) u_dly_ang (
        .aclk  (aclk),
        .en    (adv),
        .d_in  ({s1_reg, s2_reg, s3_reg}),
        .d_out (ang_src)
    );

    assign a1 = signed'(ang_src[3*SW-1 -: SW]);
    assign a2 = signed'(ang_src[2*SW-1 -: SW]);
    assign a3 = signed'(ang_src[SW-1:0]);

    // sign-extend the scaled Stokes values; the linear root is zero-extended
    logic signed [XW-1:0] psi_x, psi_y, chi_x, chi_y;
    assign psi_x = XW'(signed'({a1, 16'h0000}));
    assign psi_y = XW'(signed'({a2, 16'h0000}));
    assign chi_x = signed'(XW'(lin_root));
    assign chi_y = XW'(signed'({a3, 16'h0000}));

    cordic_res_t psi_res, chi_res;

    stk_cordic #(.XW(XW), .STEPS(CORDIC_STEPS)) u_cordic_psi (
        .aclk    (aclk),
        .en      (adv),
        .x_in    (psi_x),
        .y_in    (psi_y),
        .res_out (psi_res)
    );

    stk_cordic #(.XW(XW), .STEPS(CORDIC_STEPS)) u_cordic_chi (
        .aclk    (aclk),
        .en      (adv),
        .x_in    (chi_x),
        .y_in    (chi_y),
        .res_out (chi_res)
    );

    // degree: total root over S0
    logic [SW-1:0]    div_den;
    logic [QUO_W-1:0] quo;

    stk_delay #(.W(SW), .DEPTH(2 + TRW)) u_dly_den (
        .aclk  (aclk),
        .en    (adv),
        .d_in  (s0_reg),
        .d_out (div_den)
    );

    stk_div #(.NW(TRW), .DW(SW)) u_div (
        .aclk    (aclk),
        .en      (adv),
        .num_in  (tot_root),
        .den_in  (div_den),
        .quo_out (quo)
    );

    // bring everything to the final stage
    logic [2*CRW-1:0] ang_end;
    logic [QUO_W-1:0] quo_end;
    logic [4*SW-1:0]  stk_end;
    cordic_res_t      psi_end, chi_end;
    logic        [SW-1:0] e0;
    logic signed [SW-1:0] e1, e2, e3;

    stk_delay #(.W(2*CRW), .DEPTH(TE - TC)) u_dly_res (
        .aclk  (aclk),
        .en    (adv),
        .d_in  ({psi_res, chi_res}),
        .d_out (ang_end)
    );

    stk_delay #(.W(QUO_W), .DEPTH(TE - TD)) u_dly_quo (
        .aclk  (aclk),
        .en    (adv),
        .d_in  (quo),
        .d_out (quo_end)
    );

    stk_delay #(.W(4*SW), .DEPTH(TE - 1)) u_dly_stk (
        .aclk  (aclk),
        .en    (adv),
        .d_in  ({s0_reg, s1_reg, s2_reg, s3_reg}),
        .d_out (stk_end)
    );

    assign psi_end = ang_end[2*CRW-1 -: CRW];
    assign chi_end = ang_end[CRW-1:0];
    assign e0      = stk_end[4*SW-1 -: SW];
    assign e1      = signed'(stk_end[3*SW-1 -: SW]);
    assign e2      = signed'(stk_end[2*SW-1 -: SW]);
    assign e3      = signed'(stk_end[SW-1:0]);

    // output register
    logic        [STOKES_W-1:0] s0_out_reg;
    logic signed [STOKES_W-1:0] s1_out_reg, s2_out_reg, s3_out_reg;
    logic        [DEG_W-1:0]    deg_reg;
    logic signed [ORI_W-1:0]    ori_reg;
    logic signed [ELL_W-1:0]    ell_reg;
    logic                       zero_reg;
    logic                       zero_next;

    assign zero_next = (e0 == '0);

    always_ff @(posedge aclk) begin
        if (adv) begin
            s0_out_reg <= STOKES_W'(e0);
            s1_out_reg <= STOKES_W'(e1);
            s2_out_reg <= STOKES_W'(e2);
            s3_out_reg <= STOKES_W'(e3);
            deg_reg    <= zero_next ? '0 : DEG_W'(quo_end);
            ori_reg    <= ORI_W'(half_angle(psi_end, ORI_LIM));
            ell_reg    <= ELL_W'(half_angle(chi_end, ELL_LIM));
            zero_reg   <= zero_next;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_stokes_s0      = s0_out_reg;
    assign m_stokes_s1      = s1_out_reg;
    assign m_stokes_s2      = s2_out_reg;
    assign m_stokes_s3      = s3_out_reg;
    assign m_degree         = deg_reg;
    assign m_orientation    = ori_reg;
    assign m_ellipticity    = ell_reg;
    assign m_zero_intensity = zero_reg;

endmodule
`default_nettype wire

>>> verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stokes calculator testbench
// Drives intensity samples through the block with random gaps on both sides
// and checks every output field against a local fixed-point Stokes/CORDIC
// predictor, plus typed-in values on the directed rows.
// ----------------------------------------------------------------------------
module testbench;
    import stk_pkg::*;

    localparam int IB        = 16;
    localparam int STEPS     = 16;
    localparam int N_RANDOM  = 600;
    localparam int LATENCY   = 54;
    localparam int MAX_CYC   = 200000;

    typedef struct {
        logic [15:0] h, v, dp, dm, cp, cm;
        logic        known;
        logic [16:0] s0;
        logic [15:0] deg;
        logic [15:0] ori;
        logic [14:0] ell;
        logic        zf;
    } sample_row_t;

    typedef struct {
        logic        [16:0] s0;
        logic signed [16:0] s1, s2, s3;
        logic        [15:0] deg;
        logic signed [15:0] ori;
        logic signed [14:0] ell;
        logic               zf;
    } stokes_out_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [15:0] s_h = '0, s_v = '0, s_dp = '0, s_dm = '0, s_cp = '0, s_cm = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [16:0] m_s0;
    logic signed [16:0] m_s1, m_s2, m_s3;
    logic [15:0] m_deg;
    logic signed [15:0] m_ori;
    logic signed [14:0] m_ell;
    logic m_zf;

    stokes_out_t pending_q[$];
    int errors = 0;
    int cycles = 0;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    stokes_parameter_calculator_top #(.INTENSITY_BITS(IB), .CORDIC_STEPS(STEPS)) u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_int_horizontal(s_h), .s_int_vertical(s_v),
        .s_int_diag_plus(s_dp), .s_int_diag_minus(s_dm),
        .s_int_circ_plus(s_cp), .s_int_circ_minus(s_cm),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_stokes_s0(m_s0), .m_stokes_s1(m_s1), .m_stokes_s2(m_s2),
        .m_stokes_s3(m_s3), .m_degree(m_deg), .m_orientation(m_ori),
        .m_ellipticity(m_ell), .m_zero_intensity(m_zf)
    );

    function automatic longint floor_shift(longint v, int k);
        return (v < 0) ? ~((~v) >>> k) : (v >>> k);
    endfunction

    // floor(sqrt(m) * 2^frac), digit by digit
    function automatic longint unsigned sqrt_fixed(longint unsigned m, int frac);
        longint unsigned rem, root, trial, pair;
        rem = 0;
        root = 0;
        for (int i = 31 + frac; i >= 0; i--) begin
            pair = (i >= frac) ? ((m >> (2 * (i - frac))) & 3) : 0;
            rem = (rem << 2) | pair;
            trial = (root << 2) | 1;
            root = root << 1;
            if (rem >= trial) begin
                rem = rem - trial;
                root = root | 1;
            end
        end
        return root;
    endfunction

    function automatic longint atan_val(int i);
        longint t[24] = '{262144, 154753, 81767, 41506, 20834, 10427, 5215, 2608,
                          1304, 652, 326, 163, 81, 41, 20, 10, 5, 3, 1, 1, 0, 0, 0, 0};
        return t[i];
    endfunction

    // vectoring CORDIC, result is half-angle output scale, clamped
    function automatic longint half_atan2(longint x, longint y, longint lim);
        longint z, dx, dy, q;
        z = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            z = (y >= 0) ? ANG_PI : -ANG_PI;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < STEPS && i < ATAN_LEN; i++) begin
            dx = floor_shift(y, i);
            dy = floor_shift(x, i);
            if (y >= 0) begin
                x += dx; y -= dy; z += atan_val(i);
            end else begin
                x -= dx; y += dy; z -= atan_val(i);
            end
        end
        q = floor_shift(z + HALF_RND, HALF_SH);
        if (q > lim) q = lim;
        if (q < -lim) q = -lim;
        return q;
    endfunction

    function automatic stokes_out_t predict_stokes(sample_row_t r);
        stokes_out_t o;
        longint s0, s1, s2, s3, d;
        longint unsigned lin2, tot2;
        s0 = longint'(r.h) + longint'(r.v);
        s1 = longint'(r.h) - longint'(r.v);
        s2 = longint'(r.dp) - longint'(r.dm);
        s3 = longint'(r.cp) - longint'(r.cm);
        lin2 = s1 * s1 + s2 * s2;
        tot2 = lin2 + s3 * s3;
        o.zf = (s0 == 0);
        d = 0;
        if (s0 != 0) begin
            d = longint'(sqrt_fixed(tot2, DEG_FRAC) / longint'(s0));
            if (d > 65535) d = 65535;
        end
        o.s0 = 17'(s0);
        o.s1 = 17'(s1);
        o.s2 = 17'(s2);
        o.s3 = 17'(s3);
        o.deg = 16'(d);
        o.ori = 16'(half_atan2(s1 * 65536, s2 * 65536, ORI_LIM));
        o.ell = 15'(half_atan2(longint'(sqrt_fixed(lin2, LIN_FRAC)), s3 * 65536, ELL_LIM));
        return o;
    endfunction

    task automatic report_mismatch(string field, longint got, longint want);
        $display("MISMATCH %s: got %0d expected %0d", field, got, want);
        errors++;
    endtask

    // called at a falling edge; leaves s_valid high after the transfer
    task automatic send_sample(sample_row_t r);
        stokes_out_t e;
        int gap;
        gap = $urandom_range(0, 15);
        if ($urandom_range(0, 3) == 0) gap = 0;
        e = predict_stokes(r);
        if (r.known) begin
            if (e.s0 != r.s0 || e.deg != r.deg || e.ori != 16'(r.ori)
                || e.ell != 15'(r.ell) || e.zf != r.zf)
                $display("note: directed row disagrees with predictor");
            e.s0 = r.s0; e.deg = r.deg; e.ori = r.ori; e.ell = r.ell; e.zf = r.zf;
        end
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_h <= r.h; s_v <= r.v; s_dp <= r.dp; s_dm <= r.dm; s_cp <= r.cp; s_cm <= r.cm;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_q.push_back(e);
        @(negedge aclk);
    endtask

    function automatic sample_row_t mk(int h, int v, int dp, int dm, int cp, int cm);
        sample_row_t r;
        r.h = 16'(h); r.v = 16'(v); r.dp = 16'(dp); r.dm = 16'(dm);
        r.cp = 16'(cp); r.cm = 16'(cm);
        r.known = 1'b0;
        r.s0 = '0; r.deg = '0; r.ori = '0; r.ell = '0; r.zf = 1'b0;
        return r;
    endfunction

    function automatic sample_row_t mk_known(int h, int v, int dp, int dm, int cp, int cm,
                                             int s0, int deg, int ori, int ell, int zf);
        sample_row_t r;
        r = mk(h, v, dp, dm, cp, cm);
        r.known = 1'b1;
        r.s0 = 17'(s0); r.deg = 16'(deg); r.ori = 16'(ori); r.ell = 15'(ell);
        r.zf = 1'(zf);
        return r;
    endfunction

    function automatic logic [15:0] rand_intensity();
        case ($urandom_range(0, 5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'($urandom_range(0, 15));
            default: return 16'($urandom);
        endcase
    endfunction

    sample_row_t directed[$];

    // result side: random stall per result
    initial begin
        stokes_out_t e;
        int stall;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
            @(negedge aclk);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            if (pending_q.size() == 0) begin
                report_mismatch("unexpected transfer", 1, 0);
            end else begin
                e = pending_q.pop_front();
                if (m_s0 !== e.s0) report_mismatch("s0", m_s0, e.s0);
                if (m_s1 !== e.s1) report_mismatch("s1", m_s1, e.s1);
                if (m_s2 !== e.s2) report_mismatch("s2", m_s2, e.s2);
                if (m_s3 !== e.s3) report_mismatch("s3", m_s3, e.s3);
                if (m_deg !== e.deg) report_mismatch("degree", m_deg, e.deg);
                if (m_ori !== e.ori) report_mismatch("orientation", m_ori, e.ori);
                if (m_ell !== e.ell) report_mismatch("ellipticity", m_ell, e.ell);
                if (m_zf !== e.zf) report_mismatch("zero_intensity", m_zf, e.zf);
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYC) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        sample_row_t r;
        // all dark: zero intensity flag, angles 0
        directed.push_back(mk_known(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1));
        // unpolarized full scale
        directed.push_back(mk_known(65535, 65535, 65535, 65535, 65535, 65535,
                                    131070, 0, 0, 0, 0));
        // pure horizontal: degree 1.0
        directed.push_back(mk_known(65535, 0, 0, 0, 0, 0, 65535, 16384, 0, 0, 0));
        directed.push_back(mk(0, 65535, 0, 0, 0, 0));
        directed.push_back(mk(0, 0, 65535, 0, 0, 0));
        directed.push_back(mk(0, 0, 0, 65535, 0, 0));
        directed.push_back(mk(0, 0, 0, 0, 65535, 0));
        directed.push_back(mk(0, 0, 0, 0, 0, 65535));
        // zero total with polarized other pairs
        directed.push_back(mk(0, 0, 65535, 0, 0, 65535));
        directed.push_back(mk(0, 0, 0, 1, 1, 0));
        // degree saturates
        directed.push_back(mk(1, 0, 65535, 0, 65535, 0));
        directed.push_back(mk(0, 1, 0, 65535, 0, 65535));
        directed.push_back(mk(1, 1, 0, 0, 0, 0));
        directed.push_back(mk(0, 65535, 0, 1, 0, 0));
        directed.push_back(mk(0, 65535, 1, 0, 0, 0));
        directed.push_back(mk(100, 200, 300, 50, 7, 9000));
        directed.push_back(mk(16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA));
        directed.push_back(mk(16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555));

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed[i]) send_sample(directed[i]);
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == N_RANDOM / 2) begin
                // hold off until the pipeline has drained
                s_valid <= 1'b0;
                @(negedge aclk);
                while (pending_q.size() != 0) @(negedge aclk);
            end
            if (n % 100 < 15) begin
                // burst with no sender gaps is covered by gap draw of zero
            end
            r = mk(rand_intensity(), rand_intensity(), rand_intensity(),
                   rand_intensity(), rand_intensity(), rand_intensity());
            send_sample(r);
        end
        s_valid <= 1'b0;
        while (pending_q.size() != 0) @(negedge aclk);
        repeat (LATENCY + 10) @(negedge aclk);
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

>>> sim.f
sv/stk_pkg.sv
sv/stk_delay.sv
sv/stk_sqrt.sv
sv/stk_div.sv
sv/stk_cordic.sv
sv/stokes_parameter_calculator_top.sv
verif/testbench.sv
